FILE: hdl/ttrc_pkg.sv
`timescale 1ns / 1ps
package ttrc_pkg;

   // Field and datapath widths
   localparam int COORD_W    = 32;
   localparam int SPAN_W     = 31;
   localparam int TOL_W      = 16;
   localparam int WIDE_W     = 36;
   localparam int NUM_LANES  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 4 * COORD_W;
   localparam int RSP_PAD_W  = 6;

   // Lanes 0 and 2 take the low side of a box, lanes 1 and 3 the high side
   localparam logic [NUM_LANES-1:0] LANE_HIGH = 4'b1010;

   // Register reset values
   localparam logic [SPAN_W-1:0] TILE_SPAN_RESET  = 31'd16777216;
   localparam logic [SPAN_W-1:0] IMAGE_SPAN_RESET = 31'd67108864;
   localparam logic [TOL_W-1:0]  TOL_RESET        = 16'd1;

   typedef enum logic [1:0] {
      ST_OUTSIDE  = 2'd0,
      ST_INSIDE   = 2'd1,
      ST_BASED    = 2'd2,
      ST_STRADDLE = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILE_WIDTH   = 3'd0,
      CSR_TILE_HEIGHT  = 3'd1,
      CSR_IMAGE_WIDTH  = 3'd2,
      CSR_IMAGE_HEIGHT = 3'd3,
      CSR_REPEAT_S     = 3'd4,
      CSR_REPEAT_T     = 3'd5,
      CSR_TOLERANCE    = 3'd6
   } csr_reg_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   // Box and its early classification, carried past the image divider
   typedef struct packed {
      logic      in_image;
      logic      outside;
      coord_type s_low;
      coord_type s_high;
      coord_type t_low;
      coord_type t_high;
   } box_sb_type;

   // Repeat results, carried past the tile divider
   typedef struct packed {
      status_type status;
      coord_type  repeat_col;
      coord_type  repeat_row;
      coord_type  repeat_cols;
      coord_type  repeat_rows;
      coord_type  base_s;
      coord_type  base_t;
   } rep_sb_type;

   // Result transaction, last field (status) in the lowest bits
   typedef struct packed {
      coord_type  base_t;
      coord_type  base_s;
      coord_type  tile_rows;
      coord_type  tile_cols;
      coord_type  tile_row;
      coord_type  tile_col;
      coord_type  repeat_rows;
      coord_type  repeat_cols;
      coord_type  repeat_row;
      coord_type  repeat_col;
      status_type status;
   } rsp_type;

endpackage

FILE: hdl/ttrc_locate_pipe.sv
`timescale 1ns / 1ps
// Four-lane pipelined restoring divider, one quotient bit per stage, followed
// by a stage that turns quotient and remainder into a tolerance-nudged index.
module ttrc_locate_pipe #(
   parameter int DW = ttrc_pkg::COORD_W,
   parameter int SW = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en_i,
   input  logic                             vld_i,
   input  logic signed [DW-1:0]             dvd_i  [ttrc_pkg::NUM_LANES],
   input  logic [ttrc_pkg::SPAN_W-1:0]      p_s_i,
   input  logic [ttrc_pkg::SPAN_W-1:0]      p_t_i,
   input  logic [ttrc_pkg::TOL_W-1:0]       tol_i,
   input  logic [SW-1:0]                    sb_i,
   output logic                             vld_o,
   output logic signed [DW+1:0]             idx_o  [ttrc_pkg::NUM_LANES],
   output logic signed [ttrc_pkg::SPAN_W+1:0] srem_o [ttrc_pkg::NUM_LANES],
   output logic signed [1:0]                adj_o  [ttrc_pkg::NUM_LANES],
   output logic [SW-1:0]                    sb_o
);
   import ttrc_pkg::*;

   logic [DW:0]   vld_ff;
   logic          out_vld_ff;
   logic [SW-1:0] sb_ff [DW+1];
   logic [SW-1:0] out_sb_ff;

   // Advance valid bits and sideband with the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en_i) begin
         vld_ff     <= {vld_ff[DW-1:0], vld_i};
         out_vld_ff <= vld_ff[DW];
      end
   end

   always_ff @(posedge clock) begin
      if (en_i) begin
         sb_ff[0] <= sb_i;
         for (int k = 0; k < DW; k++) begin
            sb_ff[k+1] <= sb_ff[k];
         end
         out_sb_ff <= sb_ff[DW];
      end
   end

   assign vld_o = out_vld_ff;
   assign sb_o  = out_sb_ff;

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [SPAN_W-1:0]        p;
      logic                     high;
      logic [SPAN_W-1:0]        rem_ff [DW+1];
      logic [DW-1:0]            dvd_ff [DW+1];
      logic                     neg_ff [DW+1];
      logic [SPAN_W-1:0]        rem_in [DW+1];
      logic [DW-1:0]            dvd_in [DW+1];
      logic [SPAN_W:0]          trial  [DW];
      logic                     ge     [DW];
      logic signed [DW+1:0]     quo;
      logic signed [DW+1:0]     idx_in;
      logic signed [DW+1:0]     idx_ff;
      logic signed [SPAN_W+1:0] srem_in;
      logic signed [SPAN_W+1:0] srem_ff;
      logic signed [1:0]        adj_in;
      logic signed [1:0]        adj_ff;
      logic [SPAN_W:0]          rem_x;
      logic [SPAN_W:0]          p_x;
      logic [SPAN_W:0]          e_x;
      logic                     lt_e;
      logic                     gt_pe;

      assign p    = (l < 2) ? p_s_i : p_t_i;
      assign high = LANE_HIGH[l];

      // Take the magnitude, then one restoring step per stage
      always_comb begin
         dvd_in[0] = dvd_i[l][DW-1] ? -dvd_i[l] : dvd_i[l];
         rem_in[0] = '0;
         for (int k = 0; k < DW; k++) begin
            trial[k]    = {rem_ff[k], dvd_ff[k][DW-1]};
            ge[k]       = trial[k] >= {1'b0, p};
            rem_in[k+1] = ge[k] ? SPAN_W'(trial[k] - {1'b0, p}) : trial[k][SPAN_W-1:0];
            dvd_in[k+1] = {dvd_ff[k][DW-2:0], ge[k]};
         end
      end

      // Nudge the truncated quotient by the tolerance rules of each side
      always_comb begin
         quo   = signed'({2'b00, dvd_ff[DW]});
         rem_x = {1'b0, rem_ff[DW]};
         p_x   = {1'b0, p};
         e_x   = (SPAN_W+1)'(tol_i);
         lt_e  = rem_x < e_x;
         gt_pe = (rem_x + e_x) > p_x;
         case ({neg_ff[DW], high})
            2'b00:   adj_in = gt_pe ? 2'sd1 : 2'sd0;
            2'b01:   adj_in = lt_e ? -2'sd1 : 2'sd0;
            2'b10:   adj_in = lt_e ? 2'sd0 : -2'sd1;
            default: adj_in = gt_pe ? -2'sd2 : -2'sd1;
         endcase
         if (neg_ff[DW]) begin
            quo     = -quo;
            srem_in = -signed'({1'b0, rem_x});
         end else begin
            srem_in = signed'({1'b0, rem_x});
         end
         idx_in = quo + (DW+2)'(adj_in);
      end

      always_ff @(posedge clock) begin
         if (en_i) begin
            rem_ff[0] <= rem_in[0];
            dvd_ff[0] <= dvd_in[0];
            neg_ff[0] <= dvd_i[l][DW-1];
            for (int k = 0; k < DW; k++) begin
               rem_ff[k+1] <= rem_in[k+1];
               dvd_ff[k+1] <= dvd_in[k+1];
               neg_ff[k+1] <= neg_ff[k];
            end
            idx_ff  <= idx_in;
            srem_ff <= srem_in;
            adj_ff  <= adj_in;
         end
      end

      assign idx_o[l]  = idx_ff;
      assign srem_o[l] = srem_ff;
      assign adj_o[l]  = adj_ff;
   end

endmodule

FILE: hdl/texture_tile_range_classifier_top.sv
`timescale 1ns / 1ps
// Throughput: one box per cycle while the response is not stalled; the two pipelined
// dividers (image span, 32 stages, then tile span, 36 stages) take one new box every cycle.
// A stalled response freezes the whole pipeline, nothing is dropped.
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults: 256.0 tiles, 1024.0 image, no repeat, tolerance 1 LSB.
module texture_tile_range_classifier_top (
   input  logic                                clock,
   input  logic                                reset,
   // s_low, s_high, t_low, t_high
   input  logic [ttrc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // status, repeat_col, repeat_row, repeat_cols, repeat_rows, tile_col,
   // tile_row, tile_cols, tile_rows, base_s, base_t, zero pad
   output logic [$bits(ttrc_pkg::rsp_type)+ttrc_pkg::RSP_PAD_W-1:0] rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ttrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ttrc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ttrc_pkg::*;

   localparam int IMG_IDX_W  = COORD_W + 2;
   localparam int TILE_IDX_W = WIDE_W + 2;

   // Configuration registers
   logic [SPAN_W-1:0] tile_w_ff, tile_h_ff, image_w_ff, image_h_ff;
   logic              repeat_s_ff, repeat_t_ff;
   logic [TOL_W-1:0]  tol_ff;
   logic [SPAN_W-1:0] tw, th, iw, ih;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_w_ff   <= TILE_SPAN_RESET;
         tile_h_ff   <= TILE_SPAN_RESET;
         image_w_ff  <= IMAGE_SPAN_RESET;
         image_h_ff  <= IMAGE_SPAN_RESET;
         repeat_s_ff <= 1'b0;
         repeat_t_ff <= 1'b0;
         tol_ff      <= TOL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TILE_WIDTH:   tile_w_ff   <= csr_data[SPAN_W-1:0];
            CSR_TILE_HEIGHT:  tile_h_ff   <= csr_data[SPAN_W-1:0];
            CSR_IMAGE_WIDTH:  image_w_ff  <= csr_data[SPAN_W-1:0];
            CSR_IMAGE_HEIGHT: image_h_ff  <= csr_data[SPAN_W-1:0];
            CSR_REPEAT_S:     repeat_s_ff <= csr_data[0];
            CSR_REPEAT_T:     repeat_t_ff <= csr_data[0];
            CSR_TOLERANCE:    tol_ff      <= csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // A zero span counts as one
   assign tw = (tile_w_ff == '0)  ? SPAN_W'(1) : tile_w_ff;
   assign th = (tile_h_ff == '0)  ? SPAN_W'(1) : tile_h_ff;
   assign iw = (image_w_ff == '0) ? SPAN_W'(1) : image_w_ff;
   assign ih = (image_h_ff == '0) ? SPAN_W'(1) : image_h_ff;

   wide_type e_w, iw_w, ih_w;
   assign e_w  = wide_type'({{(WIDE_W-TOL_W){1'b0}}, tol_ff});
   assign iw_w = wide_type'({{(WIDE_W-SPAN_W){1'b0}}, iw});
   assign ih_w = wide_type'({{(WIDE_W-SPAN_W){1'b0}}, ih});

   // Whole pipeline moves while the response register is free or taken
   logic en;
   logic rsp_vld_ff;
   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   // Input stage
   logic      in_vld_ff;
   coord_type sl_ff, sh_ff, tl_ff, th_ff;

   always_ff @(posedge clock) begin
      if (reset)   in_vld_ff <= 1'b0;
      else if (en) in_vld_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sl_ff <= req_tdata[COORD_W-1:0];
         sh_ff <= req_tdata[2*COORD_W-1:COORD_W];
         tl_ff <= req_tdata[3*COORD_W-1:2*COORD_W];
         th_ff <= req_tdata[4*COORD_W-1:3*COORD_W];
      end
   end

   // Classify outside and inside on the raw box
   wide_type   sl_w, sh_w, tl_w, th_w;
   logic       inside_c, outside_c;
   box_sb_type box_c;

   always_comb begin
      sl_w      = WIDE_W'(sl_ff);
      sh_w      = WIDE_W'(sh_ff);
      tl_w      = WIDE_W'(tl_ff);
      th_w      = WIDE_W'(th_ff);
      outside_c = (!repeat_t_ff && (tl_w >= ih_w - e_w || th_w <= e_w)) ||
                  (!repeat_s_ff && (sl_w >= iw_w - e_w || sh_w <= e_w));
      inside_c  = (sl_w > -e_w) && (sh_w <= iw_w + e_w) &&
                  (tl_w > -e_w) && (th_w <= ih_w + e_w);
      box_c     = '{inside_c, outside_c, sl_ff, sh_ff, tl_ff, th_ff};
   end

   // Image-span division
   logic signed [COORD_W-1:0]   img_dvd  [NUM_LANES];
   logic                        img_vld;
   logic signed [IMG_IDX_W-1:0] img_idx  [NUM_LANES];
   logic signed [SPAN_W+1:0]    img_srem [NUM_LANES];
   logic signed [1:0]           img_adj  [NUM_LANES];
   logic [$bits(box_sb_type)-1:0] img_sb;

   assign img_dvd[0] = sl_ff;
   assign img_dvd[1] = sh_ff;
   assign img_dvd[2] = tl_ff;
   assign img_dvd[3] = th_ff;

   ttrc_locate_pipe #(
      .DW (COORD_W),
      .SW ($bits(box_sb_type))
   ) u_img_pipe (
      .clock  (clock),
      .reset  (reset),
      .en_i   (en),
      .vld_i  (in_vld_ff),
      .dvd_i  (img_dvd),
      .p_s_i  (iw),
      .p_t_i  (ih),
      .tol_i  (tol_ff),
      .sb_i   (box_c),
      .vld_o  (img_vld),
      .idx_o  (img_idx),
      .srem_o (img_srem),
      .adj_o  (img_adj),
      .sb_o   (img_sb)
   );

   // Stage R1: repeat indices, counts and exact bases
   box_sb_type img_box;
   wide_type   bs_in, bt_in, adj_s_w, adj_t_w;
   coord_type  col_in, row_in, cols_in, rows_in;
   logic       r1_vld_ff;
   box_sb_type r1_box_ff;
   coord_type  r1_col_ff, r1_row_ff, r1_cols_ff, r1_rows_ff;
   wide_type   r1_bs_ff, r1_bt_ff;

   always_comb begin
      img_box = box_sb_type'(img_sb);
      case (img_adj[0])
         2'sd1:   adj_s_w = iw_w;
         -2'sd1:  adj_s_w = -iw_w;
         default: adj_s_w = '0;
      endcase
      case (img_adj[2])
         2'sd1:   adj_t_w = ih_w;
         -2'sd1:  adj_t_w = -ih_w;
         default: adj_t_w = '0;
      endcase
      if (repeat_s_ff) begin
         bs_in   = WIDE_W'(img_box.s_low) - WIDE_W'(img_srem[0]) + adj_s_w;
         col_in  = img_idx[0][COORD_W-1:0];
         cols_in = img_idx[1][COORD_W-1:0] - img_idx[0][COORD_W-1:0] + COORD_W'(1);
      end else begin
         bs_in   = '0;
         col_in  = '0;
         cols_in = COORD_W'(1);
      end
      if (repeat_t_ff) begin
         bt_in   = WIDE_W'(img_box.t_low) - WIDE_W'(img_srem[2]) + adj_t_w;
         row_in  = img_idx[2][COORD_W-1:0];
         rows_in = img_idx[3][COORD_W-1:0] - img_idx[2][COORD_W-1:0] + COORD_W'(1);
      end else begin
         bt_in   = '0;
         row_in  = '0;
         rows_in = COORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)   r1_vld_ff <= 1'b0;
      else if (en) r1_vld_ff <= img_vld;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_box_ff  <= img_box;
         r1_col_ff  <= col_in;
         r1_row_ff  <= row_in;
         r1_cols_ff <= cols_in;
         r1_rows_ff <= rows_in;
         r1_bs_ff   <= bs_in;
         r1_bt_ff   <= bt_in;
      end
   end

   // Stage R2: shift the box by the bases, saturate the bases
   wide_type   ssl_in, ssh_in, stl_in, sth_in;
   coord_type  bs_sat_in, bt_sat_in;
   logic       r2_vld_ff;
   box_sb_type r2_box_ff;
   coord_type  r2_col_ff, r2_row_ff, r2_cols_ff, r2_rows_ff, r2_bs_ff, r2_bt_ff;
   wide_type   r2_sl_ff, r2_sh_ff, r2_tl_ff, r2_th_ff;

   always_comb begin
      ssl_in = WIDE_W'(r1_box_ff.s_low)  - r1_bs_ff;
      ssh_in = WIDE_W'(r1_box_ff.s_high) - r1_bs_ff;
      stl_in = WIDE_W'(r1_box_ff.t_low)  - r1_bt_ff;
      sth_in = WIDE_W'(r1_box_ff.t_high) - r1_bt_ff;
      if (r1_bs_ff[WIDE_W-1:COORD_W-1] == '0 || r1_bs_ff[WIDE_W-1:COORD_W-1] == '1)
         bs_sat_in = r1_bs_ff[COORD_W-1:0];
      else
         bs_sat_in = r1_bs_ff[WIDE_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                        : {1'b0, {(COORD_W-1){1'b1}}};
      if (r1_bt_ff[WIDE_W-1:COORD_W-1] == '0 || r1_bt_ff[WIDE_W-1:COORD_W-1] == '1)
         bt_sat_in = r1_bt_ff[COORD_W-1:0];
      else
         bt_sat_in = r1_bt_ff[WIDE_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                        : {1'b0, {(COORD_W-1){1'b1}}};
   end

   always_ff @(posedge clock) begin
      if (reset)   r2_vld_ff <= 1'b0;
      else if (en) r2_vld_ff <= r1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_box_ff  <= r1_box_ff;
         r2_col_ff  <= r1_col_ff;
         r2_row_ff  <= r1_row_ff;
         r2_cols_ff <= r1_cols_ff;
         r2_rows_ff <= r1_rows_ff;
         r2_bs_ff   <= bs_sat_in;
         r2_bt_ff   <= bt_sat_in;
         r2_sl_ff   <= ssl_in;
         r2_sh_ff   <= ssh_in;
         r2_tl_ff   <= stl_in;
         r2_th_ff   <= sth_in;
      end
   end

   // Stage R3: final status, pick the box for the tile division
   status_type st_in;
   logic       based_c;
   rep_sb_type rep_in;
   logic       r3_vld_ff;
   rep_sb_type r3_rep_ff;
   wide_type   r3_dvd_ff [NUM_LANES];

   always_comb begin
      based_c = (r2_sl_ff > -e_w) && (r2_sh_ff < iw_w + e_w) &&
                (r2_tl_ff > -e_w) && (r2_th_ff <= ih_w + e_w);
      if (r2_box_ff.outside)       st_in = ST_OUTSIDE;
      else if (r2_box_ff.in_image) st_in = ST_INSIDE;
      else if (based_c)            st_in = ST_BASED;
      else                         st_in = ST_STRADDLE;
      if (st_in == ST_BASED || st_in == ST_STRADDLE)
         rep_in = '{st_in, r2_col_ff, r2_row_ff, r2_cols_ff, r2_rows_ff,
                    r2_bs_ff, r2_bt_ff};
      else
         rep_in = '{st_in, '0, '0, '0, '0, '0, '0};
   end

   always_ff @(posedge clock) begin
      if (reset)   r3_vld_ff <= 1'b0;
      else if (en) r3_vld_ff <= r2_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r3_rep_ff <= rep_in;
         if (r2_box_ff.in_image) begin
            r3_dvd_ff[0] <= WIDE_W'(r2_box_ff.s_low);
            r3_dvd_ff[1] <= WIDE_W'(r2_box_ff.s_high);
            r3_dvd_ff[2] <= WIDE_W'(r2_box_ff.t_low);
            r3_dvd_ff[3] <= WIDE_W'(r2_box_ff.t_high);
         end else begin
            r3_dvd_ff[0] <= r2_sl_ff;
            r3_dvd_ff[1] <= r2_sh_ff;
            r3_dvd_ff[2] <= r2_tl_ff;
            r3_dvd_ff[3] <= r2_th_ff;
         end
      end
   end

   // Tile-span division
   logic                         tile_vld;
   logic signed [TILE_IDX_W-1:0] tile_idx [NUM_LANES];
   logic [$bits(rep_sb_type)-1:0] tile_sb;

   ttrc_locate_pipe #(
      .DW (WIDE_W),
      .SW ($bits(rep_sb_type))
   ) u_tile_pipe (
      .clock  (clock),
      .reset  (reset),
      .en_i   (en),
      .vld_i  (r3_vld_ff),
      .dvd_i  (r3_dvd_ff),
      .p_s_i  (tw),
      .p_t_i  (th),
      .tol_i  (tol_ff),
      .sb_i   (r3_rep_ff),
      .vld_o  (tile_vld),
      .idx_o  (tile_idx),
      .srem_o (),
      .adj_o  (),
      .sb_o   (tile_sb)
   );

   // Output stage: tile counts, clear fields the status leaves unset
   rep_sb_type tile_rep;
   rsp_type    rsp_in;
   rsp_type    rsp_data_ff;

   always_comb begin
      tile_rep           = rep_sb_type'(tile_sb);
      rsp_in.status      = tile_rep.status;
      rsp_in.repeat_col  = tile_rep.repeat_col;
      rsp_in.repeat_row  = tile_rep.repeat_row;
      rsp_in.repeat_cols = tile_rep.repeat_cols;
      rsp_in.repeat_rows = tile_rep.repeat_rows;
      rsp_in.base_s      = tile_rep.base_s;
      rsp_in.base_t      = tile_rep.base_t;
      if (tile_rep.status == ST_INSIDE || tile_rep.status == ST_BASED) begin
         rsp_in.tile_col  = tile_idx[0][COORD_W-1:0];
         rsp_in.tile_row  = tile_idx[2][COORD_W-1:0];
         rsp_in.tile_cols = tile_idx[1][COORD_W-1:0] - tile_idx[0][COORD_W-1:0]
                            + COORD_W'(1);
         rsp_in.tile_rows = tile_idx[3][COORD_W-1:0] - tile_idx[2][COORD_W-1:0]
                            + COORD_W'(1);
      end else begin
         rsp_in.tile_col  = '0;
         rsp_in.tile_row  = '0;
         rsp_in.tile_cols = '0;
         rsp_in.tile_rows = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)   rsp_vld_ff <= 1'b0;
      else if (en) rsp_vld_ff <= tile_vld;
   end

   always_ff @(posedge clock) begin
      if (en) rsp_data_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff};

   // Unset fields must read as zero for each status
   a_outside_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_data_ff.status == ST_OUTSIDE |->
      rsp_data_ff.repeat_cols == '0 && rsp_data_ff.tile_cols == '0 &&
      rsp_data_ff.base_s == '0 && rsp_data_ff.base_t == '0)
      else $error("outside response carries set fields");

   a_inside_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_data_ff.status == ST_INSIDE |->
      rsp_data_ff.repeat_col == '0 && rsp_data_ff.repeat_rows == '0 &&
      rsp_data_ff.base_s == '0 && rsp_data_ff.base_t == '0)
      else $error("inside response carries repeat fields");

   a_straddle_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_data_ff.status == ST_STRADDLE |->
      rsp_data_ff.tile_col == '0 && rsp_data_ff.tile_rows == '0)
      else $error("straddling response carries tile fields");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_vld_ff && !in_vld_ff)
      else $error("pipeline not empty after reset");

endmodule

FILE: tb/sv/texture_tile_range_classifier_top_tb.sv
`timescale 1ns / 1ps
module texture_tile_range_classifier_top_tb;
   import ttrc_pkg::*;

   localparam int RSP_W        = $bits(rsp_type) + RSP_PAD_W;
   localparam int LATENCY      = 77;
   localparam int IDLE_LIMIT   = 20000;
   localparam int PHASE_ITEMS  = 240;
   localparam int PHASE_COUNT  = 8;

   logic                    clock;
   logic                    reset;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [RSP_W-1:0]        rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   // Register shadow used by the classifier prediction
   longint tile_w, tile_h, image_w, image_h, wrap_s, wrap_t, tol;

   rsp_type boxes_due[$];
   int      errors;
   int      quiet_cycles;
   int      stall_left;
   bit      idle_on;

   texture_tile_range_classifier_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Index of the span cell holding a coordinate, nudged by the tolerance
   function automatic longint span_index(longint p, longint v, bit high_side, longint e);
      longint i;
      longint q;
      i = v / p;
      q = i * p;
      if (v >= 0) begin
         if (high_side) begin
            if (v < q + e) i--;
         end else begin
            if (v > q + p - e) i++;
         end
      end else begin
         if (high_side) begin
            i--;
            if (v < q - p + e) i--;
         end else begin
            if (v <= q - e) i--;
         end
      end
      return i;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic rsp_type classify_box(longint s0, longint s1, longint t0, longint t1);
      rsp_type r;
      longint  e, tw, th, iw, ih, ic, jc, nc, nr, bs, bt, lo_c, lo_r;
      r  = '0;
      e  = tol;
      tw = (tile_w == 0) ? 1 : tile_w;
      th = (tile_h == 0) ? 1 : tile_h;
      iw = (image_w == 0) ? 1 : image_w;
      ih = (image_h == 0) ? 1 : image_h;
      if ((!wrap_t && (t0 >= ih - e || t1 <= e)) || (!wrap_s && (s0 >= iw - e || s1 <= e))) begin
         r.status = ST_OUTSIDE;
         return r;
      end
      if (s0 > -e && s1 <= iw + e && t0 > -e && t1 <= ih + e) begin
         r.status = ST_INSIDE;
      end else begin
         ic = span_index(iw, s0, 1'b0, e);
         jc = span_index(ih, t0, 1'b0, e);
         nc = span_index(iw, s1, 1'b1, e) - ic + 1;
         nr = span_index(ih, t1, 1'b1, e) - jc + 1;
         bs = 0;
         bt = 0;
         if (wrap_s) begin
            bs = iw * ic;
            s0 -= bs;
            s1 -= bs;
         end else begin
            ic = 0;
            nc = 1;
         end
         if (wrap_t) begin
            bt = ih * jc;
            t0 -= bt;
            t1 -= bt;
         end else begin
            jc = 0;
            nr = 1;
         end
         r.repeat_col  = 32'(ic);
         r.repeat_row  = 32'(jc);
         r.repeat_cols = 32'(nc);
         r.repeat_rows = 32'(nr);
         r.base_s      = 32'(clip32(bs));
         r.base_t      = 32'(clip32(bt));
         if (!(s0 > -e && s1 < iw + e && t0 > -e && t1 <= ih + e)) begin
            r.status = ST_STRADDLE;
            return r;
         end
         r.status = ST_BASED;
      end
      lo_c        = span_index(tw, s0, 1'b0, e);
      lo_r        = span_index(th, t0, 1'b0, e);
      r.tile_col  = 32'(lo_c);
      r.tile_row  = 32'(lo_r);
      r.tile_cols = 32'(span_index(tw, s1, 1'b1, e) - lo_c + 1);
      r.tile_rows = 32'(span_index(th, t1, 1'b1, e) - lo_r + 1);
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // Response side: random stalls, compare each transaction with the oldest prediction
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_type)-1:0];
            if (boxes_due.size() == 0) begin
               report("unexpected response", got.status, -1);
            end else begin
               want = boxes_due.pop_front();
               if (got.status != want.status) report("status", got.status, want.status);
               if (got.repeat_col != want.repeat_col)
                  report("repeat_col", got.repeat_col, want.repeat_col);
               if (got.repeat_row != want.repeat_row)
                  report("repeat_row", got.repeat_row, want.repeat_row);
               if (got.repeat_cols != want.repeat_cols)
                  report("repeat_cols", got.repeat_cols, want.repeat_cols);
               if (got.repeat_rows != want.repeat_rows)
                  report("repeat_rows", got.repeat_rows, want.repeat_rows);
               if (got.tile_col != want.tile_col) report("tile_col", got.tile_col, want.tile_col);
               if (got.tile_row != want.tile_row) report("tile_row", got.tile_row, want.tile_row);
               if (got.tile_cols != want.tile_cols)
                  report("tile_cols", got.tile_cols, want.tile_cols);
               if (got.tile_rows != want.tile_rows)
                  report("tile_rows", got.tile_rows, want.tile_rows);
               if (got.base_s != want.base_s) report("base_s", got.base_s, want.base_s);
               if (got.base_t != want.base_t) report("base_t", got.base_t, want.base_t);
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready && idle_on) stall_left <= $urandom_range(0, 17);
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("texture_tile_range_classifier_top_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_box(longint s0, longint s1, longint t0, longint t1);
      int gap;
      // Treat each coordinate as the 32-bit signed value that goes on the bus
      s0  = longint'(coord_type'(s0));
      s1  = longint'(coord_type'(s1));
      t0  = longint'(coord_type'(t0));
      t1  = longint'(coord_type'(t1));
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {32'(t1), 32'(t0), 32'(s1), 32'(s0)};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      boxes_due = {boxes_due, classify_box(s0, s1, t0, t1)};
   endtask

   // Hold until every predicted response has arrived
   task automatic drain(bit settle);
      req_tvalid <= 1'b0;
      while (boxes_due.size() != 0) @(posedge clock);
      if (settle) repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(csr_reg_type idx, logic [31:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TILE_WIDTH:   tile_w  = value[30:0];
         CSR_TILE_HEIGHT:  tile_h  = value[30:0];
         CSR_IMAGE_WIDTH:  image_w = value[30:0];
         CSR_IMAGE_HEIGHT: image_h = value[30:0];
         CSR_REPEAT_S:     wrap_s  = value[0];
         CSR_REPEAT_T:     wrap_t  = value[0];
         CSR_TOLERANCE:    tol     = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(longint tw, longint th, longint iw, longint ih,
                            bit rs, bit rt, longint e);
      drain(1'b1);
      write_csr(CSR_TILE_WIDTH, 32'(tw));
      write_csr(CSR_TILE_HEIGHT, 32'(th));
      write_csr(CSR_IMAGE_WIDTH, 32'(iw));
      write_csr(CSR_IMAGE_HEIGHT, 32'(ih));
      write_csr(CSR_REPEAT_S, 32'(rs));
      write_csr(CSR_REPEAT_T, 32'(rt));
      write_csr(CSR_TOLERANCE, 32'(e));
   endtask

   function automatic longint pick_span();
      case ($urandom_range(0, 5))
         0:       return 1;
         1:       return $urandom_range(1, 4096);
         2:       return $urandom_range(32'h10000, 32'h4000000);
         3:       return 32'h7FFFFFFF;
         default: return $urandom_range(1, 32'h7FFFFFFF);
      endcase
   endfunction

   // Coordinate from a multiple of the image span, half the time within 65538 of that boundary
   function automatic longint near_edge(longint span);
      longint v;
      v = (longint'($urandom_range(0, 6)) - 3) * span;
      if ($urandom_range(0, 1)) v += longint'($urandom_range(0, 2 * 65536 + 4)) - 65538;
      else v += longint'($urandom_range(0, 32'h7FFFFFFF)) % span;
      return clip32(v);
   endfunction

   task automatic random_box();
      longint s0, s1, t0, t1;
      if ($urandom_range(0, 9) == 0) begin
         s0 = longint'($signed($urandom()));
         s1 = longint'($signed($urandom()));
         t0 = longint'($signed($urandom()));
         t1 = longint'($signed($urandom()));
      end else begin
         s0 = near_edge(image_w == 0 ? 1 : image_w);
         t0 = near_edge(image_h == 0 ? 1 : image_h);
         s1 = clip32(s0 + longint'($urandom_range(0, 32'h7FFFFFFF)) %
                     ((image_w == 0 ? 1 : image_w) + 2));
         t1 = clip32(t0 + longint'($urandom_range(0, 32'h7FFFFFFF)) %
                     ((image_h == 0 ? 1 : image_h) + 2));
         if ($urandom_range(0, 15) == 0) begin
            s1 = clip32(s0 - longint'($urandom_range(0, 65536)));
         end
      end
      send_box(s0, s1, t0, t1);
   endtask

   // Default registers: inside, outside, straddle, reversed box, coordinate extremes
   task automatic test_default_boxes();
      idle_on = 1'b0;
      send_box(0, 0, 0, 0);
      send_box(32'h10000, 32'h3000000, 32'h10000, 32'h3000000);
      send_box(1, 32'h4000001, 2, 32'h4000000);
      send_box(32'h1000000, 32'h1000000, 32'h0FFFFFF, 32'h2000001);
      send_box(-2147483648, 2147483647, -2147483648, 2147483647);
      send_box(32'h3FFFFFF, 32'h5000000, 32'h100, 32'h200);
      send_box(32'h100, 32'h200, 1, 1);
      send_box(32'h2000000, 32'h1000000, 32'h2000000, 32'h1000000);
      send_box(-1, 32'h100000, 0, 32'h100000);
      send_box(32'h10000, 32'h4000002, 32'h10000, 32'h20000);
   endtask

   // Repeat on both axes and on s alone: negative boxes, base shift and base saturation
   task automatic test_repeat_boxes();
      write_all(32'h1000000, 32'h1000000, 32'h4000000, 32'h4000000, 1'b1, 1'b1, 1);
      idle_on = 1'b1;
      send_box(32'h4100000, 32'h4200000, -32'h3F00000, -32'h3E00000);
      send_box(-32'h4000000, -32'h1, 32'h8000000, 32'hC000000);
      send_box(32'h3F00000, 32'h4100000, 32'h100, 32'h200);
      send_box(-2147483648, -2147483648, 2147483647, 2147483647);
      write_all(32'h7FFFFFFF, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b0, 0);
      send_box(-2147483648, -2147483647, 32'h100, 32'h200);
      send_box(2147483647, 2147483647, 32'h100, 32'h7FFFFFFF);
      write_all(0, 0, 0, 0, 1'b1, 1'b1, 16'hFFFF);
      send_box(-5, 7, 100000, -100000);
      send_box(2147483647, -2147483648, 0, 65535);
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: write_all(1, 1, 32'h7FFFFFFF, 1, 1'b0, 1'b0, 0);
            1: write_all(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                         1'b1, 1'b1, 16'hFFFF);
            default: write_all(pick_span(), pick_span(), pick_span(), pick_span(),
                               1'($urandom()), 1'($urandom()),
                               $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 16));
         endcase
         idle_on = (ph % 3) != 2;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 3 && n == PHASE_ITEMS / 2) drain(1'b0);
            random_box();
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tdata  <= '0;
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_TILE_WIDTH;
      csr_data   <= '0;
      errors     = 0;
      idle_on    = 1'b0;
      tile_w     = TILE_SPAN_RESET;
      tile_h     = TILE_SPAN_RESET;
      image_w    = IMAGE_SPAN_RESET;
      image_h    = IMAGE_SPAN_RESET;
      wrap_s     = 0;
      wrap_t     = 0;
      tol        = TOL_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_boxes();
      test_repeat_boxes();
      test_random_settings();
      drain(1'b1);
      if (errors == 0) begin
         $display("texture_tile_range_classifier_top_tb OK");
      end else begin
         $display("texture_tile_range_classifier_top_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/ttrc_pkg.sv
hdl/ttrc_locate_pipe.sv
hdl/texture_tile_range_classifier_top.sv
tb/sv/texture_tile_range_classifier_top_tb.sv
